/* rtl/lru_pkg.sv */
// ----------------------------------------------------------------------------
// lru_pkg - shared types and constants for the LRU page replacement list
// Request and response structs, request codes, cell control struct and
// default sizes used by the top level.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Default sizes
  localparam int CAPACITY_DEF     = 8;
  localparam int PAGE_ID_BITS_DEF = 16;

  // Request codes
  localparam logic REQ_TOUCH = 1'b0;
  localparam logic REQ_EVICT = 1'b1;

  // Incoming request
  typedef struct packed {
    logic        req_type;
    logic [15:0] page_id;
  } lru_req_t;

  // Outgoing response
  typedef struct packed {
    logic [15:0] victim_page;
    logic        victim_valid;
    logic        overflow;
  } lru_rsp_t;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic touch;   // touch request accepted this cycle
    logic found;   // key matched some valid cell
    logic full;    // list holds CAPACITY pages
  } lru_cell_ctrl_t;

endpackage

/* rtl/lru_cell.sv */
// ----------------------------------------------------------------------------
// lru_cell - one slot of the recency list
// Holds one page, compares it against the broadcast key, passes the
// hit-seen chain on, and takes its left neighbor's page when told to shift.
// ----------------------------------------------------------------------------
module lru_cell #(
  parameter int IDX = 0,
  parameter int PW  = 16,
  parameter int CW  = 4
) (
  input  logic                    clk,
  input  logic [PW-1:0]           key,
  input  logic [PW-1:0]           left_page,
  input  logic [CW-1:0]           count,
  input  logic                    seen_in,
  input  lru_pkg::lru_cell_ctrl_t ctrl,
  output logic [PW-1:0]           page,
  output logic                    seen_out,
  output logic [PW-1:0]           victim_tap
);
  import lru_pkg::*;

  logic [PW-1:0] page_r;
  logic [PW-1:0] page_nxt;
  logic          valid;
  logic          hit;
  logic          shift;
  logic          is_last;

  // Decode this slot's position against the fill count
  assign valid   = CW'(IDX) < count;
  assign is_last = CW'(IDX + 1) == count;

  // Compare and extend the chain of "match seen closer to the front"
  assign hit      = valid && (page_r == key);
  assign seen_out = seen_in | hit;

  // Shift from the front up to the hit slot, or up to the first free slot
  always_comb begin
    shift = 1'b0;
    if (ctrl.touch) begin
      if (ctrl.found) begin
        shift = !seen_in;
      end else begin
        shift = !ctrl.full && (CW'(IDX) <= count);
      end
    end
    page_nxt = shift ? left_page : page_r;
  end

  // Hold or advance the stored page
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

  assign page       = page_r;
  assign victim_tap = is_last ? page_r : '0;

endmodule

/* rtl/lru_page_replacement_list_top.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement_list_top - move-to-front LRU page list
// Row of compare-and-shift cells keeping page ids newest first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_req and raise start; the request is taken at a
//   rising edge where start is high and busy is low. req_type REQ_TOUCH moves
//   page_id to the front (inserting it if absent, flagging overflow if the
//   list is full); REQ_EVICT removes and returns the oldest page.
//   Result channel: every request gives one response on out_rsp, marked by
//   out_valid for exactly one cycle, the cycle after acceptance.
//   Throughput is 1 request per cycle: all cells compare the key in
//   parallel and shift in the same edge, so busy stays low outside reset.
//   The receiver cannot stall; a response not taken in its cycle is gone.
//   Reset (rst_n low, synchronous) empties the list and holds busy high
//   until the first edge after reset is released. No clearing pass is
//   needed; the fill count marks which cells hold pages.
// ----------------------------------------------------------------------------
module lru_page_replacement_list_top #(
  parameter int CAPACITY     = lru_pkg::CAPACITY_DEF,
  parameter int PAGE_ID_BITS = lru_pkg::PAGE_ID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  lru_pkg::lru_req_t in_req,
  output logic              out_valid,
  output lru_pkg::lru_rsp_t out_rsp
);
  import lru_pkg::*;

  localparam int PW = PAGE_ID_BITS;
  localparam int CW = $clog2(CAPACITY + 1);

  logic           busy_r;
  logic           out_valid_r;
  lru_rsp_t       rsp_r;
  lru_rsp_t       rsp_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;

  logic           accept;
  logic           is_touch;
  logic           is_evict;
  logic           full;
  logic           empty;
  logic [PW-1:0]  key;
  lru_cell_ctrl_t ctrl;

  logic [PW-1:0]  pages    [CAPACITY];
  logic [PW-1:0]  taps     [CAPACITY];
  logic [CAPACITY:0] seen;
  logic [PW-1:0]  victim;

  // Decode the request
  assign accept   = start && !busy_r;
  assign is_touch = accept && (in_req.req_type == REQ_TOUCH);
  assign is_evict = accept && (in_req.req_type == REQ_EVICT);
  assign key      = PW'(in_req.page_id);
  assign full     = count_r == CW'(CAPACITY);
  assign empty    = count_r == '0;

  assign ctrl.touch = is_touch;
  assign ctrl.found = seen[CAPACITY];
  assign ctrl.full  = full;

  assign seen[0] = 1'b0;

  // Build the row of cells; cell 0 takes the key, the rest take their neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [PW-1:0] left;
    if (i == 0) begin : g_head
      assign left = key;
    end else begin : g_body
      assign left = pages[i-1];
    end
    lru_cell #(
      .IDX (i),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .key        (key),
      .left_page  (left),
      .count      (count_r),
      .seen_in    (seen[i]),
      .ctrl       (ctrl),
      .page       (pages[i]),
      .seen_out   (seen[i+1]),
      .victim_tap (taps[i])
    );
  end

  // Collect the oldest page; only the last valid cell drives its tap
  always_comb begin
    victim = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      victim = victim | taps[i];
    end
  end

  // Next fill count and response
  always_comb begin
    count_nxt = count_r;
    rsp_nxt   = '0;
    if (is_touch && !ctrl.found) begin
      if (full) begin
        rsp_nxt.overflow = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (is_evict && !empty) begin
      count_nxt            = count_r - CW'(1);
      rsp_nxt.victim_page  = 16'(victim);
      rsp_nxt.victim_valid = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= 1'b0;
      out_valid_r <= accept;
      count_r     <= count_nxt;
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // Fill count never exceeds the capacity
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("fill count above capacity");

  // Every accepted request yields a response next cycle
  a_one_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request gave no response");

  // A returned victim shrinks the list by one
  a_evict_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_evict && !empty |=> count_r == $past(count_r) - CW'(1))
    else $error("evict did not shrink the list");

  // A touch that misses a full list flags overflow and leaves the list full
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    is_touch && !ctrl.found && full |=> rsp_r.overflow && full)
    else $error("overflow handling wrong");

  // Victim and overflow are never flagged together
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(rsp_r.victim_valid && rsp_r.overflow))
    else $error("victim and overflow both set");

endmodule
